>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/rmis_pkg.sv
// ----------------------------------------------------------------------------
// rmis_pkg
// Shared types and constants of the recurrence interval search.
// ----------------------------------------------------------------------------
`default_nettype none
package rmis_pkg;
   localparam int MaxNodes = 32;
   localparam int MaxEdges = 64;
   localparam int ResultCap = 32;
   localparam int NodeW = 5;
   localparam int EdgeW = 6;
   localparam int CntW = 7;
   localparam int PathW = 48;

   localparam logic [2:0] StOk = 3'd0;
   localparam logic [2:0] StZeroCycle = 3'd1;
   localparam logic [2:0] StZeroSep = 3'd2;
   localparam logic [2:0] StBadNode = 3'd3;
   localparam logic [2:0] StInfeasible = 3'd4;

   localparam logic [1:0] ErrNone = 2'd0;
   localparam logic [1:0] ErrZeroSep = 2'd1;
   localparam logic [1:0] ErrBadNode = 2'd2;

   typedef enum logic [4:0] {
      S_LOAD,
      S_VAL_RD,
      S_VAL,
      S_VAL_END,
      S_CHK_INIT,
      S_CHK_CLR,
      S_CHK_RD,
      S_CHK_ND,
      S_CHK_UPD,
      S_CHK_END,
      S_DECIDE,
      S_WIT_WALK,
      S_WIT_WRD,
      S_WIT_LOOP,
      S_WIT_SCAN,
      S_WIT_SRD,
      S_WIT_SUM,
      S_EMIT_RD,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_ZERO,
      PH_BOUND,
      PH_BISECT,
      PH_WIT
   } phase_type;
endpackage
`default_nettype wire

>>> rtl/core/recurrence_min_interval_search_top.sv
// ----------------------------------------------------------------------------
// recurrence_min_interval_search_top
// Minimum recurrence interval search over a loaded dependence graph.
// ----------------------------------------------------------------------------
// Usage: write csr_wr_data to set the node count (reset value 1) while idle.
// Issue one edge per request with start while busy is low; edges load into
// a 64-entry synchronous store at one request per cycle. A request with
// req_last_edge raises busy and runs the search: validation of each edge,
// a Bellman-Ford check on zero-distance edges, then a bisection over the
// interval from 1 to the sum of separations. Each trial clears the 32-entry
// node memory, then runs up to node_count rounds over the stored edges,
// reading source and destination node state per edge in use and writing
// the destination back when its path improves. A witness trace of the
// critical cycle may follow the search.
// Results appear one per cycle on rsp_* marked by rsp_valid, ending with
// rsp_last_result; the receiver cannot stall, so results are never held.
// Synchronous active-high reset clears the edge count and the controller;
// the store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module recurrence_min_interval_search_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_edge_present,
   input  wire logic [4:0]  req_src_node,
   input  wire logic [4:0]  req_dst_node,
   input  wire logic [7:0]  req_iter_distance,
   input  wire logic [15:0] req_separation,
   input  wire logic        req_last_edge,
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [22:0]      rsp_rec_interval,
   output logic             rsp_witness_valid,
   output logic [5:0]       rsp_witness_edge,
   output logic [21:0]      rsp_witness_sep_total,
   output logic [12:0]      rsp_witness_dist_total,
   output logic             rsp_last_result
);
   rmis_pkg::state_type state_ff, state_in;
   rmis_pkg::phase_type phase_ff, phase_in;

   logic [33:0] edge_mem [rmis_pkg::MaxEdges];
   logic [33:0] edge_rd_ff;
   logic [5:0]  edge_ra;
   logic        edge_we;

   // node memory: {valid, pred edge, pred node, path}
   logic [rmis_pkg::PathW+11:0] node_mem [rmis_pkg::MaxNodes];
   logic [rmis_pkg::PathW+11:0] node_rd_ff;
   logic [4:0] node_ra, node_wa;
   logic [rmis_pkg::PathW+11:0] node_wd;
   logic node_we;

   logic [5:0]  ncfg_ff;
   logic [5:0]  n_eff;
   logic [6:0]  cnt_ff, cnt_in;
   logic [6:0]  eidx_ff, eidx_in;
   logic [5:0]  round_ff, round_in;
   logic        upd_ff, upd_in;
   logic [1:0]  err_ff, err_in;
   logic [21:0] ssum_ff, ssum_in;
   logic [22:0] lo_ff, lo_in, hi_ff, hi_in, ii_ff, ii_in;
   logic [4:0]  last_ff, last_in;
   logic [4:0]  cur_ff, cur_in, wstart_ff, wstart_in;
   logic [5:0]  wk_ff, wk_in;
   logic [5:0]  wcnt_ff, wcnt_in;
   logic [rmis_pkg::MaxEdges-1:0] wmask_ff, wmask_in;
   logic [21:0] wsep_ff, wsep_in;
   logic [12:0] wdist_ff, wdist_in;
   logic        have_ff, have_in;
   logic [2:0]  status_ff, status_in;
   logic [22:0] interval_ff, interval_in;
   logic [rmis_pkg::PathW-1:0] src_path_ff, src_path_in;
   logic [30:0] prod_ff, prod_in;
   logic [5:0]  emit_done_ff, emit_done_in;

   logic        accept;
   logic [4:0]  e_src, e_dst;
   logic [7:0]  e_dist;
   logic [15:0] e_sep;
   logic        e_inrange, e_used;
   logic signed [rmis_pkg::PathW-1:0] cand;
   logic [5:0]  scan_next;
   logic        scan_found;

   assign accept = start && !busy;
   assign n_eff = (ncfg_ff == 6'd0) ? 6'd1 :
                  ((ncfg_ff > 6'(rmis_pkg::MaxNodes)) ? 6'(rmis_pkg::MaxNodes) : ncfg_ff);
   assign e_src = edge_rd_ff[33:29];
   assign e_dst = edge_rd_ff[28:24];
   assign e_dist = edge_rd_ff[23:16];
   assign e_sep = edge_rd_ff[15:0];
   assign e_inrange = ({1'b0, e_src} < n_eff) && ({1'b0, e_dst} < n_eff);
   assign e_used = e_inrange && !(phase_ff == rmis_pkg::PH_ZERO && e_dist != 8'd0);
   assign cand = $signed(src_path_ff) + $signed({32'd0, e_sep})
                 - $signed({17'd0, prod_ff});
   assign edge_we = accept && req_edge_present && (cnt_ff < 7'(rmis_pkg::MaxEdges));

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[cnt_ff[5:0]] <= {req_src_node, req_dst_node, req_iter_distance,
                                   req_separation};
      end
      edge_rd_ff <= edge_mem[edge_ra];
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      node_rd_ff <= node_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmis_pkg::S_LOAD;
         phase_ff <= rmis_pkg::PH_ZERO;
         ncfg_ff <= 6'd1;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         if (csr_wr_en) begin
            ncfg_ff <= csr_wr_data;
         end
      end
      eidx_ff <= eidx_in; round_ff <= round_in; upd_ff <= upd_in;
      err_ff <= err_in; ssum_ff <= ssum_in; lo_ff <= lo_in; hi_ff <= hi_in;
      ii_ff <= ii_in; last_ff <= last_in; cur_ff <= cur_in;
      wstart_ff <= wstart_in; wk_ff <= wk_in; wcnt_ff <= wcnt_in;
      wmask_ff <= wmask_in; wsep_ff <= wsep_in; wdist_ff <= wdist_in;
      have_ff <= have_in; status_ff <= status_in; interval_ff <= interval_in;
      src_path_ff <= src_path_in; prod_ff <= prod_in; emit_done_ff <= emit_done_in;
   end

   always_comb begin
      scan_found = 1'b0;
      scan_next = 6'd0;
      for (int i = rmis_pkg::MaxEdges - 1; i >= 0; i--) begin
         if (wmask_ff[i] && (7'(i) >= eidx_ff)) begin
            scan_found = 1'b1;
            scan_next = 6'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; cnt_in = cnt_ff;
      eidx_in = eidx_ff; round_in = round_ff; upd_in = upd_ff; err_in = err_ff;
      ssum_in = ssum_ff; lo_in = lo_ff; hi_in = hi_ff; ii_in = ii_ff;
      last_in = last_ff; cur_in = cur_ff; wstart_in = wstart_ff; wk_in = wk_ff;
      wcnt_in = wcnt_ff; wmask_in = wmask_ff; wsep_in = wsep_ff;
      wdist_in = wdist_ff; have_in = have_ff; status_in = status_ff;
      interval_in = interval_ff; src_path_in = src_path_ff; prod_in = prod_ff;
      emit_done_in = emit_done_ff;
      edge_ra = eidx_ff[5:0];
      node_ra = e_src; node_wa = e_dst; node_wd = '0; node_we = 1'b0;
      unique case (state_ff)
         rmis_pkg::S_LOAD: begin
            if (edge_we) begin
               cnt_in = cnt_ff + 7'd1;
            end
            if (accept && req_last_edge) begin
               eidx_in = '0; err_in = rmis_pkg::ErrNone; ssum_in = '0;
               if (edge_we) begin
                  cnt_in = cnt_ff + 7'd1;
               end
               state_in = rmis_pkg::S_VAL_RD;
            end
         end
         rmis_pkg::S_VAL_RD: begin
            if (eidx_ff >= cnt_ff) begin
               state_in = rmis_pkg::S_VAL_END;
            end else begin
               state_in = rmis_pkg::S_VAL;
            end
         end
         rmis_pkg::S_VAL: begin
            if (e_sep == 16'd0) begin
               err_in = rmis_pkg::ErrZeroSep;
            end else if (!e_inrange) begin
               err_in = rmis_pkg::ErrBadNode;
            end else begin
               ssum_in = ssum_ff + 22'(e_sep);
            end
            eidx_in = eidx_ff + 7'd1;
            edge_ra = 6'(eidx_ff + 7'd1);
            state_in = rmis_pkg::S_VAL_RD;
         end
         rmis_pkg::S_VAL_END: begin
            have_in = 1'b0; wcnt_in = '0; wsep_in = '0; wdist_in = '0;
            if (err_ff != rmis_pkg::ErrNone) begin
               status_in = (err_ff == rmis_pkg::ErrZeroSep) ? rmis_pkg::StZeroSep
                                                             : rmis_pkg::StBadNode;
               interval_in = '0;
               state_in = rmis_pkg::S_EMIT_RD;
            end else if (cnt_ff == 7'd0) begin
               status_in = rmis_pkg::StOk; interval_in = 23'd1;
               state_in = rmis_pkg::S_EMIT_RD;
            end else begin
               phase_in = rmis_pkg::PH_ZERO; ii_in = '0;
               state_in = rmis_pkg::S_CHK_INIT;
            end
         end
         rmis_pkg::S_CHK_INIT: begin
            eidx_in = '0; last_in = '0;
            state_in = rmis_pkg::S_CHK_CLR;
         end
         rmis_pkg::S_CHK_CLR: begin
            node_we = 1'b1; node_wa = eidx_ff[4:0]; node_wd = '0;
            eidx_in = eidx_ff + 7'd1;
            if (eidx_ff == 7'(rmis_pkg::MaxNodes - 1)) begin
               eidx_in = '0; round_in = '0; upd_in = 1'b0;
               state_in = rmis_pkg::S_CHK_RD;
            end
         end
         rmis_pkg::S_CHK_RD: begin
            if (eidx_ff >= cnt_ff) begin
               state_in = rmis_pkg::S_CHK_END;
            end else begin
               state_in = rmis_pkg::S_CHK_ND;
            end
         end
         rmis_pkg::S_CHK_ND: begin
            // edge data now registered; fetch source node
            node_ra = e_src;
            prod_in = 31'(e_dist) * 31'(ii_ff);
            state_in = e_used ? rmis_pkg::S_CHK_UPD : rmis_pkg::S_CHK_RD;
            if (!e_used) begin
               eidx_in = eidx_ff + 7'd1;
               edge_ra = 6'(eidx_ff + 7'd1);
            end
         end
         rmis_pkg::S_CHK_UPD: begin
            // source path latched; read destination
            src_path_in = node_rd_ff[rmis_pkg::PathW-1:0];
            node_ra = e_dst;
            state_in = rmis_pkg::S_WIT_WRD;
            phase_in = phase_ff;
         end
         rmis_pkg::S_WIT_WRD: begin
            if ($signed(node_rd_ff[rmis_pkg::PathW-1:0]) < cand) begin
               node_we = 1'b1; node_wa = e_dst;
               node_wd = {1'b1, eidx_ff[5:0], e_src, cand};
               last_in = e_dst; upd_in = 1'b1;
            end
            eidx_in = eidx_ff + 7'd1;
            edge_ra = 6'(eidx_ff + 7'd1);
            state_in = rmis_pkg::S_CHK_RD;
         end
         rmis_pkg::S_CHK_END: begin
            eidx_in = '0; edge_ra = '0;
            if (!upd_ff) begin
               state_in = rmis_pkg::S_DECIDE; upd_in = 1'b1;
            end else if (round_ff + 6'd1 >= n_eff) begin
               state_in = rmis_pkg::S_DECIDE; upd_in = 1'b0;
            end else begin
               round_in = round_ff + 6'd1; upd_in = 1'b0;
               state_in = rmis_pkg::S_CHK_RD;
            end
         end
         rmis_pkg::S_DECIDE: begin
            // upd_ff high here means feasible
            unique case (phase_ff)
               rmis_pkg::PH_ZERO: begin
                  if (!upd_ff) begin
                     status_in = rmis_pkg::StZeroCycle; interval_in = '0;
                     cur_in = last_ff; wk_in = '0; phase_in = rmis_pkg::PH_WIT;
                     state_in = rmis_pkg::S_WIT_WALK;
                  end else begin
                     lo_in = 23'd1;
                     hi_in = (ssum_ff > 22'd1) ? 23'(ssum_ff) : 23'd1;
                     ii_in = (ssum_ff > 22'd1) ? 23'(ssum_ff) : 23'd1;
                     phase_in = rmis_pkg::PH_BOUND;
                     state_in = rmis_pkg::S_CHK_INIT;
                  end
               end
               rmis_pkg::PH_BOUND, rmis_pkg::PH_BISECT: begin
                  if (phase_ff == rmis_pkg::PH_BOUND && !upd_ff) begin
                     status_in = rmis_pkg::StInfeasible; interval_in = '0;
                     state_in = rmis_pkg::S_EMIT_RD;
                  end else begin
                     if (phase_ff == rmis_pkg::PH_BISECT) begin
                        if (upd_ff) begin
                           hi_in = ii_ff;
                        end else begin
                           lo_in = ii_ff + 23'd1;
                        end
                     end
                     phase_in = rmis_pkg::PH_BISECT;
                     if (lo_in < hi_in) begin
                        ii_in = lo_in + ((hi_in - lo_in) >> 1);
                        state_in = rmis_pkg::S_CHK_INIT;
                     end else if (lo_in > 23'd1 && ii_ff != lo_in - 23'd1) begin
                        ii_in = lo_in - 23'd1;
                        state_in = rmis_pkg::S_CHK_INIT;
                        phase_in = rmis_pkg::PH_WIT;
                        status_in = rmis_pkg::StOk; interval_in = lo_in;
                     end else if (lo_in > 23'd1) begin
                        // last trial was lo - 1 and infeasible: trace it
                        status_in = rmis_pkg::StOk; interval_in = lo_in;
                        cur_in = last_ff; wk_in = '0; phase_in = rmis_pkg::PH_WIT;
                        state_in = rmis_pkg::S_WIT_WALK;
                     end else begin
                        status_in = rmis_pkg::StOk; interval_in = lo_in;
                        state_in = rmis_pkg::S_EMIT_RD;
                     end
                  end
               end
               rmis_pkg::PH_WIT: begin
                  if (!upd_ff) begin
                     cur_in = last_ff; wk_in = '0;
                     state_in = rmis_pkg::S_WIT_WALK;
                  end else begin
                     state_in = rmis_pkg::S_EMIT_RD;
                  end
               end
            endcase
         end
         rmis_pkg::S_WIT_WALK: begin
            node_ra = cur_ff;
            wmask_in = '0; wcnt_in = '0;
            state_in = rmis_pkg::S_WIT_SCAN;
         end
         rmis_pkg::S_WIT_SCAN: begin
            // node_rd_ff holds cur's entry
            if (!node_rd_ff[rmis_pkg::PathW+11]) begin
               state_in = rmis_pkg::S_EMIT_RD;
            end else if (wk_ff < n_eff) begin
               cur_in = node_rd_ff[rmis_pkg::PathW+4:rmis_pkg::PathW];
               wk_in = wk_ff + 6'd1;
               state_in = rmis_pkg::S_WIT_WALK;
               if (wk_ff + 6'd1 == n_eff) begin
                  wstart_in = node_rd_ff[rmis_pkg::PathW+4:rmis_pkg::PathW];
                  state_in = rmis_pkg::S_WIT_LOOP;
               end
            end else begin
               wmask_in[node_rd_ff[rmis_pkg::PathW+10:rmis_pkg::PathW+5]] = 1'b1;
               wcnt_in = wcnt_ff + 6'd1;
               cur_in = node_rd_ff[rmis_pkg::PathW+4:rmis_pkg::PathW];
               if (wcnt_ff + 6'd1 > n_eff + 6'd1
                   || wcnt_ff + 6'd1 > 6'(rmis_pkg::ResultCap)) begin
                  state_in = rmis_pkg::S_EMIT_RD;
               end else if (node_rd_ff[rmis_pkg::PathW+4:rmis_pkg::PathW]
                            == wstart_ff) begin
                  eidx_in = '0; state_in = rmis_pkg::S_WIT_SRD;
               end else begin
                  state_in = rmis_pkg::S_WIT_LOOP;
               end
            end
         end
         rmis_pkg::S_WIT_LOOP: begin
            node_ra = cur_ff;
            wk_in = 6'(rmis_pkg::MaxNodes);
            state_in = rmis_pkg::S_WIT_SCAN;
         end
         rmis_pkg::S_WIT_SRD: begin
            if (!scan_found) begin
               have_in = 1'b1; eidx_in = '0;
               state_in = rmis_pkg::S_EMIT_RD;
            end else begin
               edge_ra = scan_next;
               eidx_in = 7'(scan_next) + 7'd1;
               state_in = rmis_pkg::S_WIT_SUM;
            end
         end
         rmis_pkg::S_WIT_SUM: begin
            wsep_in = wsep_ff + 22'(e_sep);
            wdist_in = wdist_ff + 13'(e_dist);
            state_in = rmis_pkg::S_WIT_SRD;
         end
         rmis_pkg::S_EMIT_RD: begin
            eidx_in = '0; emit_done_in = '0;
            state_in = rmis_pkg::S_EMIT;
         end
         rmis_pkg::S_EMIT: begin
            emit_done_in = emit_done_ff + 6'd1;
            eidx_in = 7'(scan_next) + 7'd1;
            if (!have_ff || emit_done_ff + 6'd1 >= wcnt_ff) begin
               cnt_in = '0; ssum_in = '0; phase_in = rmis_pkg::PH_ZERO;
               state_in = rmis_pkg::S_LOAD;
            end
         end
         default: state_in = rmis_pkg::S_LOAD;
      endcase
   end

   always_comb begin
      busy = (state_ff != rmis_pkg::S_LOAD);
      rsp_valid = (state_ff == rmis_pkg::S_EMIT);
      rsp_status = status_ff;
      rsp_rec_interval = interval_ff;
      rsp_witness_valid = have_ff;
      rsp_witness_edge = have_ff ? scan_next : 6'd0;
      rsp_witness_sep_total = have_ff ? wsep_ff : 22'd0;
      rsp_witness_dist_total = have_ff ? wdist_ff : 13'd0;
      rsp_last_result = !have_ff || (emit_done_ff + 6'd1 >= wcnt_ff);
   end
endmodule
`default_nettype wire

>>> rtl/core/rmis_checker.sv
// ----------------------------------------------------------------------------
// rmis_checker
// Port-level checks of the search block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rmis_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic busy,
   input wire logic start,
   input wire logic req_last_edge,
   input wire logic rsp_valid,
   input wire logic rsp_witness_valid,
   input wire logic rsp_last_result,
   input wire logic [2:0] rsp_status
);
   logic wit_status_ok;

   assign wit_status_ok = (rsp_status == rmis_pkg::StOk)
                          || (rsp_status == rmis_pkg::StZeroCycle);

   `ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, busy)
   `ASSERT_NEXT(a_last_starts, clock, reset, start && !busy && req_last_edge, busy)
   `ASSERT_NEXT(a_last_frees, clock, reset, rsp_valid && rsp_last_result, !busy)
   `ASSERT_IMP(a_wit_ok, clock, reset, rsp_valid && rsp_witness_valid, wit_status_ok)
endmodule

bind recurrence_min_interval_search_top rmis_checker u_chk (
   .clock(clock), .reset(reset), .busy(busy), .start(start),
   .req_last_edge(req_last_edge), .rsp_valid(rsp_valid),
   .rsp_witness_valid(rsp_witness_valid), .rsp_last_result(rsp_last_result),
   .rsp_status(rsp_status)
);
`default_nettype wire
